// ----- rtl/gab_pkg.sv -----
// Shared types, constants and helper functions for the glyph alpha blitter.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package gab_pkg;

    localparam int GLYPH_SIDE_MAX_DEF = 64;
    localparam int FB_SIDE_MAX        = 2048;

    localparam int COLOR_W  = 16;
    localparam int FBDIM_W  = 12;
    localparam int GDIM_W   = 7;
    localparam int COORD_W  = 12;
    localparam int ALPHA_W  = 4;
    localparam int ADDR_W   = 22;
    localparam int REGIDX_W = 3;
    localparam int CFGDAT_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 4'hF;

    // Division by 15 of a blend sum below 1024: multiply by a scaled reciprocal.
    localparam int DIV15_RECIP = 2185;
    localparam int DIV15_SHIFT = 15;

    localparam int SUM_W = 10;

    typedef enum logic [REGIDX_W-1:0] {
        REG_TEXT_COLOR   = 3'd0,
        REG_FB_WIDTH     = 3'd1,
        REG_FB_HEIGHT    = 3'd2,
        REG_GLYPH_WIDTH  = 3'd3,
        REG_GLYPH_HEIGHT = 3'd4,
        REG_ORIGIN_X     = 3'd5,
        REG_ORIGIN_Y     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0]        text_color;
        logic [FBDIM_W-1:0]        fb_width;
        logic [FBDIM_W-1:0]        fb_height;
        logic [GDIM_W-1:0]         glyph_width;
        logic [GDIM_W-1:0]         glyph_height;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
    } t_cfg;

    // One classified pixel on its way from the front end to the blend pipeline.
    typedef struct packed {
        logic                we;
        logic                last;
        logic [ALPHA_W-1:0]  alpha;
        logic [COORD_W-1:0]  xx;
        logic [COORD_W-1:0]  yy;
        logic [COLOR_W-1:0]  dest;
    } t_item;

    function automatic logic [COLOR_W-1:0] swap16(input logic [COLOR_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [FBDIM_W-1:0] clamp_fb(input logic [FBDIM_W-1:0] v);
        logic [FBDIM_W+1:0] lim;
        lim = (FBDIM_W+2)'(FB_SIDE_MAX);
        if ((FBDIM_W+2)'(v) > lim) begin
            return lim[FBDIM_W-1:0];
        end
        return v;
    endfunction

    function automatic logic [SUM_W-1:0] mix_sum(input logic [5:0] s, input logic [5:0] d,
                                                 input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] na;
        na = ALPHA_FULL - a;
        return SUM_W'(SUM_W'(s) * SUM_W'(a)) + SUM_W'(SUM_W'(d) * SUM_W'(na));
    endfunction

    function automatic logic [5:0] div15(input logic [SUM_W-1:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(DIV15_RECIP);
        return p[DIV15_SHIFT+5:DIV15_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gab_front.sv -----
// Front end: accepts glyph pixels, tracks row, column and nibble parity,
// picks the alpha and clips the target position. Depends on gab_pkg.
`default_nettype none

module gab_front import gab_pkg::*; #(
    parameter int GLYPH_SIDE_MAX = GLYPH_SIDE_MAX_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_glyph_byte,
    input  wire logic [COLOR_W-1:0] i_dest_pixel,
    output logic                    o_push_valid,
    input  wire logic               i_push_ready,
    output t_item                   o_item
);

    localparam int CNT_W = $clog2(GLYPH_SIDE_MAX);
    localparam int CMP_W = ((CNT_W > GDIM_W) ? CNT_W : GDIM_W) + 1;
    localparam int XW    = (((CNT_W + 1) > COORD_W) ? (CNT_W + 1) : COORD_W) + 1;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             r_parity, n_parity;

    logic [CMP_W-1:0]     gw, gh;
    logic                 end_row, end_cell, accept, in_frame;
    logic [ALPHA_W-1:0]   alpha;
    logic signed [XW-1:0] xx, yy;
    logic [FBDIM_W-1:0]   fw, fh;

    function automatic logic [CMP_W-1:0] clamp_glyph(input logic [GDIM_W-1:0] v);
        if (v == '0) begin
            return CMP_W'(1);
        end
        if (CMP_W'(v) > CMP_W'(GLYPH_SIDE_MAX)) begin
            return CMP_W'(GLYPH_SIDE_MAX);
        end
        return CMP_W'(v);
    endfunction

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign accept       = i_valid && i_push_ready;

    always_comb begin
        gw       = clamp_glyph(i_cfg.glyph_width);
        gh       = clamp_glyph(i_cfg.glyph_height);
        fw       = clamp_fb(i_cfg.fb_width);
        fh       = clamp_fb(i_cfg.fb_height);
        end_row  = (CMP_W'(r_col) + CMP_W'(1)) >= gw;
        end_cell = end_row && ((CMP_W'(r_row) + CMP_W'(1)) >= gh);
        alpha    = r_parity ? i_glyph_byte[3:0] : i_glyph_byte[7:4];
        xx       = XW'(i_cfg.origin_x) + signed'(XW'(r_col));
        yy       = XW'(i_cfg.origin_y) + signed'(XW'(r_row));
        in_frame = !xx[XW-1] && !yy[XW-1]
                   && (xx[XW-2:0] < (XW-1)'(fw)) && (yy[XW-2:0] < (XW-1)'(fh));

        o_item.we    = in_frame && (alpha != '0);
        o_item.last  = end_cell;
        o_item.alpha = alpha;
        o_item.xx    = xx[COORD_W-1:0];
        o_item.yy    = yy[COORD_W-1:0];
        o_item.dest  = i_dest_pixel;
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_parity = r_parity;
        if (accept) begin
            if (end_cell) begin
                n_col    = '0;
                n_row    = '0;
                n_parity = 1'b0;
            end else begin
                if (end_row) begin
                    n_col = '0;
                    n_row = r_row + CNT_W'(1);
                end else begin
                    n_col = r_col + CNT_W'(1);
                end
                n_parity = !r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_parity <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_parity <= n_parity;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gab_queue.sv -----
// Short queue that decouples the front end from the blend pipeline.
// Holds classified pixels of type t_item from gab_pkg.
`default_nettype none

module gab_queue import gab_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr  = pop  ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gab_back.sv -----
// Back end: two-stage pipeline that forms the pixel address and the blended
// colour, ending in the output register. Depends on gab_pkg.
`default_nettype none

module gab_back import gab_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_item               i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_we,
    output logic [ADDR_W-1:0]        o_addr,
    output logic [COLOR_W-1:0]       o_value,
    output logic                     o_last
);

    localparam int PROD_W = 2 * COORD_W;

    typedef struct packed {
        logic               we;
        logic               last;
        logic               opaque;
        logic [COLOR_W-1:0] dest;
        logic [COORD_W-1:0] xx;
        logic [PROD_W-1:0]  prod;
        logic [SUM_W-1:0]   sum_r;
        logic [SUM_W-1:0]   sum_g;
        logic [SUM_W-1:0]   sum_b;
    } t_mix;

    logic               r_s1_valid;
    t_mix               r_s1, n_s1;
    logic               s1_adv, out_adv;
    logic [COLOR_W-1:0] s_host, d_host, blend_host, n_value;
    logic [PROD_W-1:0]  n_addr_full;
    logic [5:0]         q_r, q_g, q_b;

    logic                r_out_valid;
    logic                r_out_we;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [COLOR_W-1:0]  r_out_value;
    logic                r_out_last;

    assign out_adv = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || out_adv;
    assign s1_adv  = i_valid && o_ready;

    // Stage one: row times width, and the per-channel weighted sums.
    always_comb begin
        s_host       = swap16(i_cfg.text_color);
        d_host       = swap16(i_item.dest);
        n_s1.we      = i_item.we;
        n_s1.last    = i_item.last;
        n_s1.opaque  = (i_item.alpha == ALPHA_FULL);
        n_s1.dest    = i_item.dest;
        n_s1.xx      = i_item.xx;
        n_s1.prod    = PROD_W'(i_item.yy) * PROD_W'(clamp_fb(i_cfg.fb_width));
        n_s1.sum_r   = mix_sum({1'b0, s_host[15:11]}, {1'b0, d_host[15:11]}, i_item.alpha);
        n_s1.sum_g   = mix_sum(s_host[10:5], d_host[10:5], i_item.alpha);
        n_s1.sum_b   = mix_sum({1'b0, s_host[4:0]}, {1'b0, d_host[4:0]}, i_item.alpha);
    end

    // Stage two: divide by 15, add the column, and pick the written value.
    always_comb begin
        q_r         = div15(r_s1.sum_r);
        q_g         = div15(r_s1.sum_g);
        q_b         = div15(r_s1.sum_b);
        blend_host  = {q_r[4:0], q_g, q_b[4:0]};
        n_addr_full = r_s1.prod + PROD_W'(r_s1.xx);
        if (!r_s1.we) begin
            n_value = r_s1.dest;
        end else if (r_s1.opaque) begin
            n_value = i_cfg.text_color;
        end else begin
            n_value = swap16(blend_host);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (out_adv && r_s1_valid) begin
            r_out_we    <= r_s1.we;
            r_out_addr  <= r_s1.we ? n_addr_full[ADDR_W-1:0] : '0;
            r_out_value <= n_value;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_we    = r_out_we;
    assign o_addr  = r_out_addr;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/glyph_alpha_blit_rgb565.sv -----
// Glyph alpha blitter top level: register file, front end, queue, back end.
// Depends on gab_pkg, gab_front, gab_queue and gab_back.
//
// Usage: write the seven registers through i_cfg_we / i_cfg_index / i_cfg_data
// while no pixel is in flight. Then stream one glyph pixel per item on the
// s_axis channel, in raster order over the glyph cell, with the packed glyph
// byte and the current framebuffer pixel at that spot. Each item gives exactly
// one result on m_axis: a write flag in tuser, the framebuffer address and the
// blended big-endian RGB565 value in tdata, and tlast on the final cell pixel.
// Items without a write carry address 0 and the destination pixel unchanged.
// A result passes through the queue register, the stage-one register and the
// output register before it is valid on m_axis.
// Throughput: one item per cycle while m_axis_tready stays high, set by the
// combinational front end and the two-stage blend pipeline behind it.
// Reset restores the register defaults, clears the row, column and nibble
// parity and empties the queue and pipeline. When the receiver stalls, the
// pipeline and the two-entry queue keep taking items until they hold four,
// then s_axis_tready drops until results are taken.
`default_nettype none

module glyph_alpha_blit_rgb565 import gab_pkg::*; #(
    parameter int GLYPH_SIDE_MAX = GLYPH_SIDE_MAX_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [REGIDX_W-1:0] i_cfg_index,
    input  wire logic [CFGDAT_W-1:0] i_cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // glyph_byte [7:0], dest_pixel [23:8]
    input  wire logic [23:0]         s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // pixel_address [21:0], pixel_value [37:22], zero fill [39:38]
    output logic [39:0]              m_axis_tdata,
    // write_enable [0]
    output logic                     m_axis_tuser,
    output logic                     m_axis_tlast
);

    t_cfg  r_cfg;
    logic  push_valid, push_ready, pop_valid, pop_ready;
    t_item push_item, pop_item;
    logic  out_we, out_last;
    logic [ADDR_W-1:0]  out_addr;
    logic [COLOR_W-1:0] out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color   <= 16'hFFFF;
            r_cfg.fb_width     <= FBDIM_W'(480);
            r_cfg.fb_height    <= FBDIM_W'(480);
            r_cfg.glyph_width  <= GDIM_W'(8);
            r_cfg.glyph_height <= GDIM_W'(16);
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TEXT_COLOR:   r_cfg.text_color   <= i_cfg_data;
                REG_FB_WIDTH:     r_cfg.fb_width     <= i_cfg_data[FBDIM_W-1:0];
                REG_FB_HEIGHT:    r_cfg.fb_height    <= i_cfg_data[FBDIM_W-1:0];
                REG_GLYPH_WIDTH:  r_cfg.glyph_width  <= i_cfg_data[GDIM_W-1:0];
                REG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[GDIM_W-1:0];
                REG_ORIGIN_X:     r_cfg.origin_x     <= signed'(i_cfg_data[COORD_W-1:0]);
                REG_ORIGIN_Y:     r_cfg.origin_y     <= signed'(i_cfg_data[COORD_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    gab_front #(
        .GLYPH_SIDE_MAX (GLYPH_SIDE_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_glyph_byte (s_axis_tdata[7:0]),
        .i_dest_pixel (s_axis_tdata[23:8]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    gab_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    gab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pop_valid),
        .o_ready (pop_ready),
        .i_item  (pop_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_we    (out_we),
        .o_addr  (out_addr),
        .o_value (out_value),
        .o_last  (out_last)
    );

    assign m_axis_tdata = {2'b00, out_value, out_addr};
    assign m_axis_tuser = out_we;
    assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the glyph alpha blitter (glyph_alpha_blit_rgb565).
// Covers a directed table of corner pixels and register settings, then random phases.
// Depends on gab_pkg and the RTL under rtl/; the expected results come from a local model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gab_pkg::*;

    localparam int IDLE_PCT      = 29;
    localparam int RANDOM_ITEMS  = 950;
    localparam int STEADY_FROM   = 400;
    localparam int STEADY_TO     = 650;
    localparam int HOLD_AT       = 420;
    localparam int HOLD_CYCLES   = 48;
    localparam int HOLD_ITEMS    = 80;
    localparam int SETTLE_CYCLES = 3;
    localparam int TAIL_CYCLES   = 8;
    localparam int STALL_LIMIT   = 2000;

    // Index 7 is outside the register map and must be ignored.
    localparam logic [REGIDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
        logic              cell_end;
    } t_blit;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [REGIDX_W-1:0] idx;
        logic [15:0]         data;
        logic [7:0]          gbyte;
        logic [15:0]         dest;
        logic                fixed;
        t_blit               want;
    } t_row;

    localparam t_blit NO_WANT = '0;
    localparam int NUM_ROWS = 41;

    // Typed results are the ones that follow directly from the register values:
    // full alpha, zero alpha, clipped pixels and the far corner of a maximal framebuffer.
    t_row directed_rows [NUM_ROWS] = '{
        '{ROW_PIX, 3'd0, 16'h0000, 8'hF0, 16'h1234, 1'b1, '{1'b1, 22'h0, 16'hFFFF, 1'b0}},
        '{ROW_PIX, 3'd0, 16'h0000, 8'hF0, 16'hABCD, 1'b1, '{1'b0, 22'h0, 16'hABCD, 1'b0}},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h7A, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h3F, 16'hF81F, 1'b1, '{1'b1, 22'h3, 16'hFFFF, 1'b0}},
        '{ROW_CFG, REG_TEXT_COLOR,   16'h00F8, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_SPARE,        16'hFFFF, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_WIDTH,  16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h8F, 16'h1F00, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h8F, 16'hE007, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_WIDTH,  16'h007F, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 16'h0002, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_X,     16'h0800, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'hFF, 16'h5555, 1'b1, '{1'b0, 22'h0, 16'h5555, 1'b0}},
        '{ROW_CFG, REG_ORIGIN_X,     16'h07FE, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_Y,     16'h07FF, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_FB_WIDTH,     16'h0FFF, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_FB_HEIGHT,    16'h0FFF, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h0F, 16'h0000, 1'b1, '{1'b1, 22'h3FFFFF, 16'h00F8, 1'b0}},
        '{ROW_PIX, 3'd0, 16'h0000, 8'hF0, 16'h0000, 1'b1, '{1'b0, 22'h0, 16'h0000, 1'b0}},
        '{ROW_CFG, REG_FB_WIDTH,     16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_X,     16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_Y,     16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h0F, 16'h1234, 1'b1, '{1'b0, 22'h0, 16'h1234, 1'b0}},
        '{ROW_CFG, REG_FB_WIDTH,     16'h0001, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_FB_HEIGHT,    16'h0001, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_X,     16'h0FFC, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'hF0, 16'h4321, 1'b1, '{1'b1, 22'h0, 16'h00F8, 1'b0}},
        '{ROW_CFG, REG_GLYPH_WIDTH,  16'h0006, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 16'h0001, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h1E, 16'hFFFF, 1'b1, '{1'b0, 22'h0, 16'hFFFF, 1'b1}},
        '{ROW_CFG, REG_TEXT_COLOR,   16'hA5C3, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_FB_WIDTH,     16'h01E0, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_FB_HEIGHT,    16'h01E0, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_ORIGIN_X,     16'h0000, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_WIDTH,  16'h0040, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 16'h0040, 8'h00, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h1E, 16'h0000, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h1E, 16'hFFFF, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h5C, 16'h9E3B, 1'b0, NO_WANT},
        '{ROW_PIX, 3'd0, 16'h0000, 8'h5C, 16'h07E0, 1'b0, NO_WANT}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [REGIDX_W-1:0] i_cfg_index;
    logic [CFGDAT_W-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata;   // glyph_byte [7:0], dest_pixel [23:8]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [39:0]         m_axis_tdata;   // pixel_address [21:0], pixel_value [37:22], zero fill
    logic                m_axis_tuser;   // write_enable [0]
    logic                m_axis_tlast;

    // Shadow registers and raster position of the blitter.
    logic [15:0]         shd_color;
    logic [FBDIM_W-1:0]  shd_fb_w;
    logic [FBDIM_W-1:0]  shd_fb_h;
    logic [GDIM_W-1:0]   shd_glyph_w;
    logic [GDIM_W-1:0]   shd_glyph_h;
    logic [COORD_W-1:0]  shd_org_x;
    logic [COORD_W-1:0]  shd_org_y;
    int                  col_pos;
    int                  row_pos;
    bit                  odd_pixel;

    t_blit blit_queue [$];
    t_blit got_blit;
    t_blit want_blit;

    int  pixels_sent;
    int  results_seen;
    int  writes_seen;
    int  cells_seen;
    int  reg_writes;
    int  cfg_phases;
    int  error_count;
    bit  steady;
    bit  hold_req;

    glyph_alpha_blit_rgb565 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] blend_rgb565(input logic [15:0] dst_be,
                                                 input logic [15:0] src_be,
                                                 input logic [3:0]  a);
        logic [15:0] d;
        logic [15:0] s;
        logic [15:0] mixed;
        int unsigned k;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        if (a == ALPHA_FULL) begin
            return src_be;
        end
        d = {dst_be[7:0], dst_be[15:8]};
        s = {src_be[7:0], src_be[15:8]};
        k = ALPHA_FULL - a;
        r = (s[15:11] * a + d[15:11] * k) / int'(ALPHA_FULL);
        g = (s[10:5] * a + d[10:5] * k) / int'(ALPHA_FULL);
        b = (s[4:0] * a + d[4:0] * k) / int'(ALPHA_FULL);
        mixed = {r[4:0], g[5:0], b[4:0]};
        return {mixed[7:0], mixed[15:8]};
    endfunction

    // Works out the result of one accepted pixel and advances the raster position.
    function automatic t_blit compute_blit(input logic [7:0] gbyte, input logic [15:0] dest);
        int gw;
        int gh;
        int fw;
        int fh;
        int xx;
        int yy;
        logic [3:0] alpha;
        bit in_fb;
        bit row_end;
        bit cell_end;
        t_blit res;
        gw = (shd_glyph_w == 0) ? 1 :
             (shd_glyph_w > GLYPH_SIDE_MAX_DEF) ? GLYPH_SIDE_MAX_DEF : int'(shd_glyph_w);
        gh = (shd_glyph_h == 0) ? 1 :
             (shd_glyph_h > GLYPH_SIDE_MAX_DEF) ? GLYPH_SIDE_MAX_DEF : int'(shd_glyph_h);
        fw = (shd_fb_w > FB_SIDE_MAX) ? FB_SIDE_MAX : int'(shd_fb_w);
        fh = (shd_fb_h > FB_SIDE_MAX) ? FB_SIDE_MAX : int'(shd_fb_h);
        alpha = odd_pixel ? gbyte[3:0] : gbyte[7:4];
        xx = int'($signed(shd_org_x)) + col_pos;
        yy = int'($signed(shd_org_y)) + row_pos;
        in_fb = xx >= 0 && yy >= 0 && xx < fw && yy < fh;
        row_end = col_pos + 1 >= gw;
        cell_end = row_end && row_pos + 1 >= gh;
        res.we = in_fb && alpha != 0;
        res.addr = res.we ? ADDR_W'(yy * fw + xx) : '0;
        res.value = res.we ? blend_rgb565(dest, shd_color, alpha) : dest;
        res.cell_end = cell_end;
        if (cell_end) begin
            col_pos = 0;
            row_pos = 0;
            odd_pixel = 1'b0;
        end else begin
            if (row_end) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
            odd_pixel = !odd_pixel;
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_reg_value(input logic [REGIDX_W-1:0] idx);
        int unsigned r;
        int v;
        r = $urandom_range(0, 9);
        case (idx)
            REG_TEXT_COLOR: begin
                v = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 65535);
            end
            REG_FB_WIDTH, REG_FB_HEIGHT: begin
                v = (r == 0) ? 0 : (r == 1) ? 4095 : (r == 2) ? FB_SIDE_MAX :
                    (r == 3) ? 1 : (r < 7) ? $urandom_range(1, 40) :
                    $urandom_range(1, FB_SIDE_MAX);
            end
            REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT: begin
                v = (r == 0) ? 0 : (r == 1) ? 127 : (r == 2) ? GLYPH_SIDE_MAX_DEF :
                    (r == 3) ? 1 : $urandom_range(1, 8);
            end
            REG_ORIGIN_X: begin
                v = (r == 0) ? -2048 : (r == 1) ? 2047 :
                    (r < 4) ? int'(shd_fb_w) - int'($urandom_range(0, 8)) :
                    int'($urandom_range(0, 40)) - 20;
                v = v & 32'hFFF;
            end
            REG_ORIGIN_Y: begin
                v = (r == 0) ? -2048 : (r == 1) ? 2047 :
                    (r < 4) ? int'(shd_fb_h) - int'($urandom_range(0, 8)) :
                    int'($urandom_range(0, 40)) - 20;
                v = v & 32'hFFF;
            end
            default: begin
                v = $urandom_range(0, 65535);
            end
        endcase
        return v[15:0];
    endfunction

    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_TEXT_COLOR:   shd_color   = data;
            REG_FB_WIDTH:     shd_fb_w    = data[FBDIM_W-1:0];
            REG_FB_HEIGHT:    shd_fb_h    = data[FBDIM_W-1:0];
            REG_GLYPH_WIDTH:  shd_glyph_w = data[GDIM_W-1:0];
            REG_GLYPH_HEIGHT: shd_glyph_h = data[GDIM_W-1:0];
            REG_ORIGIN_X:     shd_org_x   = data[COORD_W-1:0];
            REG_ORIGIN_Y:     shd_org_y   = data[COORD_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering pixels and waits until every pending result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (blit_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [7:0] gbyte, input logic [15:0] dest,
                              input logic fixed, input t_blit want);
        t_blit predicted;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dest, gbyte};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = compute_blit(gbyte, dest);
        blit_queue.push_back(fixed ? want : predicted);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [7:0] gbyte;
        int unsigned r;
        r = $urandom_range(0, 7);
        gbyte = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        send_pixel(gbyte, 16'($urandom_range(0, 65535)), 1'b0, NO_WANT);
    endtask

    task automatic configure_random(input bit every);
        for (int i = 0; i <= REG_ORIGIN_Y; i++) begin
            if (every || $urandom_range(1) == 1) begin
                write_reg(REGIDX_W'(i), pick_reg_value(REGIDX_W'(i)));
            end
        end
        if ($urandom_range(7) == 0) begin
            write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        end
        cfg_phases++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: result %0d %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, results_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_blit = '{m_axis_tuser, m_axis_tdata[21:0], m_axis_tdata[37:22], m_axis_tlast};
            if (blit_queue.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, got we=%0d addr=0x%0h "
                         , $time, got_blit.we, got_blit.addr,
                         "value=0x%0h last=%0d", got_blit.value, got_blit.cell_end);
            end else begin
                want_blit = blit_queue.pop_front();
                check_field("write_enable", want_blit.we, got_blit.we);
                check_field("pixel_address", want_blit.addr, got_blit.addr);
                check_field("pixel_value", want_blit.value, got_blit.value);
                check_field("last", want_blit.cell_end, got_blit.cell_end);
            end
            results_seen++;
            if (got_blit.we) writes_seen++;
            if (got_blit.cell_end) cells_seen++;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Ends the run if no request moves on any port for too long.
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("%0t ns: no request accepted for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, blit_queue.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int n;
        bit hold_used;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        shd_color     = 16'hFFFF;
        shd_fb_w      = 12'd480;
        shd_fb_h      = 12'd480;
        shd_glyph_w   = 7'd8;
        shd_glyph_h   = 7'd16;
        shd_org_x     = '0;
        shd_org_y     = '0;
        col_pos       = 0;
        row_pos       = 0;
        odd_pixel     = 1'b0;
        pixels_sent   = 0;
        results_seen  = 0;
        writes_seen   = 0;
        cells_seen    = 0;
        reg_writes    = 0;
        cfg_phases    = 0;
        error_count   = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        hold_used     = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_pixel(directed_rows[i].gbyte, directed_rows[i].dest,
                           directed_rows[i].fixed, directed_rows[i].want);
            end
        end

        n = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < n) begin
            drain_results();
            configure_random(cfg_phases == 0);
            steady = pixels_sent >= STEADY_FROM && pixels_sent < STEADY_TO;
            if (!hold_used && pixels_sent >= HOLD_AT) begin
                // Keep offering pixels while the output is held so the input stalls.
                hold_used = 1'b1;
                hold_req = 1'b1;
                repeat (HOLD_ITEMS) send_random_pixel();
            end else begin
                repeat ($urandom_range(10, 60)) begin
                    steady = pixels_sent >= STEADY_FROM && pixels_sent < STEADY_TO;
                    send_random_pixel();
                end
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d pixels, %0d framebuffer writes and %0d finished glyph cells.",
                 pixels_sent, writes_seen, cells_seen);
        $display("%0d register writes over %0d random settings, one %0d-cycle output hold.",
                 reg_writes, cfg_phases, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gab_pkg.sv
rtl/gab_front.sv
rtl/gab_queue.sv
rtl/gab_back.sv
rtl/glyph_alpha_blit_rgb565.sv
tb/sv/tb.sv
